@@ sv/fcdma_pkg.sv @@
package fcdma_pkg;

   localparam int CHANNELS = 4;
   localparam int ADDR_BITS = 28;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_READ    = 3'd1,
      OP_VBLANK  = 3'd2,
      OP_HBLANK  = 3'd3,
      OP_FIFO    = 3'd4,
      OP_CAPTURE = 3'd5,
      OP_STEP    = 3'd6
   } op_type;

   localparam logic [1:0] TIMING_NOW    = 2'd0;
   localparam logic [1:0] TIMING_VBLANK = 2'd1;
   localparam logic [1:0] TIMING_HBLANK = 2'd2;
   localparam logic [1:0] TIMING_SPECIAL = 2'd3;

   localparam logic [1:0] RULE_INC    = 2'd0;
   localparam logic [1:0] RULE_DEC    = 2'd1;
   localparam logic [1:0] RULE_FIXED  = 2'd2;
   localparam logic [1:0] RULE_RELOAD = 2'd3;

   localparam logic [31:0] FIFO_A_ADDR = 32'h040000A0;
   localparam logic [31:0] FIFO_B_ADDR = 32'h040000A4;

   typedef struct packed {
      logic [2:0]  op;
      logic [5:0]  reg_offset;
      logic [7:0]  write_byte;
      logic        fifo_select;
      logic        last_scanline;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        xfer_valid;
      logic [1:0]  xfer_channel;
      logic [27:0] src_addr;
      logic [27:0] dst_addr;
      logic        word_size;
      logic        open_bus;
      logic        block_done;
      logic [3:0]  irq_request;
      logic [3:0]  pending_mask;
   } rsp_type;

   function automatic logic [ADDR_BITS-1:0] src_mask(input int c);
      logic [31:0] m;
      m = (c == 0) ? 32'h07FFFFFF : 32'h0FFFFFFF;
      return m[ADDR_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] dst_mask(input int c);
      logic [31:0] m;
      m = (c == 3) ? 32'h0FFFFFFF : 32'h07FFFFFF;
      return m[ADDR_BITS-1:0];
   endfunction

endpackage

@@ sv/fcdma_if.sv @@
interface fcdma_req_if;
   logic                     valid;
   logic                     ready;
   fcdma_pkg::req_type       payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fcdma_rsp_if;
   logic                     valid;
   logic                     ready;
   fcdma_pkg::rsp_type       payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/fcdma_core.sv @@
module fcdma_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  fcdma_pkg::req_type  req,
   output fcdma_pkg::rsp_type  rsp
);
   import fcdma_pkg::*;

   logic [31:0]          source_reg_ff [CHANNELS];
   logic [31:0]          source_reg_in [CHANNELS];
   logic [31:0]          dest_reg_ff   [CHANNELS];
   logic [31:0]          dest_reg_in   [CHANNELS];
   logic [15:0]          count_reg_ff  [CHANNELS];
   logic [15:0]          count_reg_in  [CHANNELS];
   logic [15:0]          control_ff    [CHANNELS];
   logic [15:0]          control_in    [CHANNELS];
   logic [ADDR_BITS-1:0] live_src_ff   [CHANNELS];
   logic [ADDR_BITS-1:0] live_src_in   [CHANNELS];
   logic [ADDR_BITS-1:0] live_dst_ff   [CHANNELS];
   logic [ADDR_BITS-1:0] live_dst_in   [CHANNELS];
   logic [16:0]          units_ff      [CHANNELS];
   logic [16:0]          units_in      [CHANNELS];
   logic [CHANNELS-1:0]  pending_ff, pending_in;
   logic [CHANNELS-1:0]  reload_ff, reload_in;

   logic [3:0]  chan;
   logic [3:0]  byte_sel;
   logic [1:0]  sel;
   logic        found;
   logic [15:0] ctl;
   logic [1:0]  tm;
   logic        audio, word, rep;
   logic [1:0]  srule, drule;
   logic [31:0] src, dst, ns, inc, smask, dmask, blk;
   logic [16:0] ul;
   logic        rl;
   logic [31:0] fifo_addr;
   logic [7:0]  hi_mask;

   always_comb begin
      if (req.reg_offset >= 6'd36) begin
         chan     = 4'd3;
         byte_sel = 4'(req.reg_offset - 6'd36);
      end else if (req.reg_offset >= 6'd24) begin
         chan     = 4'd2;
         byte_sel = 4'(req.reg_offset - 6'd24);
      end else if (req.reg_offset >= 6'd12) begin
         chan     = 4'd1;
         byte_sel = 4'(req.reg_offset - 6'd12);
      end else begin
         chan     = 4'd0;
         byte_sel = 4'(req.reg_offset);
      end
      rsp = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         source_reg_in[c] = source_reg_ff[c];
         dest_reg_in[c]   = dest_reg_ff[c];
         count_reg_in[c]  = count_reg_ff[c];
         control_in[c]    = control_ff[c];
         live_src_in[c]   = live_src_ff[c];
         live_dst_in[c]   = live_dst_ff[c];
         units_in[c]      = units_ff[c];
      end
      pending_in = pending_ff;
      reload_in  = reload_ff;
      fifo_addr = req.fifo_select ? FIFO_B_ADDR : FIFO_A_ADDR;
      sel = '0;
      found = 1'b0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (pending_ff[c]) begin
            sel = 2'(c);
            found = 1'b1;
         end
      end
      ctl = '0; tm = '0; audio = 1'b0; word = 1'b0; rep = 1'b0;
      srule = '0; drule = '0; src = '0; dst = '0; ns = '0; inc = '0;
      smask = '0; dmask = '0; blk = '0; ul = '0; rl = 1'b0; hi_mask = '0;

      case (op_type'(req.op))
         OP_WRITE: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (req.reg_offset < 6'd48 && chan == 4'(c)) begin
                  if (byte_sel < 4'd4) begin
                     source_reg_in[c][byte_sel[1:0]*8 +: 8] = req.write_byte;
                  end else if (byte_sel < 4'd8) begin
                     dest_reg_in[c][byte_sel[1:0]*8 +: 8] = req.write_byte;
                  end else if (byte_sel < 4'd10) begin
                     count_reg_in[c][byte_sel[0]*8 +: 8] = req.write_byte;
                  end else if (byte_sel == 4'd10) begin
                     control_in[c][7:0] = req.write_byte;
                  end else begin
                     if (!control_ff[c][15] && req.write_byte[7]) begin
                        live_src_in[c] = source_reg_ff[c][ADDR_BITS-1:0] & src_mask(c);
                        live_dst_in[c] = dest_reg_ff[c][ADDR_BITS-1:0] & dst_mask(c);
                        units_in[c] = '0;
                        reload_in[c] = 1'b0;
                     end
                     control_in[c][15:8] = req.write_byte;
                     if (!req.write_byte[7]) begin
                        pending_in[c] = 1'b0;
                        units_in[c] = '0;
                        reload_in[c] = 1'b0;
                     end else if (req.write_byte[5:4] == TIMING_NOW) begin
                        pending_in[c] = 1'b1;
                     end
                  end
               end
            end
         end
         OP_READ: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (req.reg_offset < 6'd48 && chan == 4'(c)) begin
                  hi_mask = (c == 3) ? 8'hFF : 8'hF7;
                  if (byte_sel == 4'd10) rsp.read_byte = control_ff[c][7:0] & 8'hE0;
                  else if (byte_sel == 4'd11) rsp.read_byte = control_ff[c][15:8] & hi_mask;
               end
            end
         end
         OP_VBLANK, OP_HBLANK: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (control_ff[c][15] && control_ff[c][13:12] ==
                   ((req.op == OP_VBLANK) ? TIMING_VBLANK : TIMING_HBLANK))
                  pending_in[c] = 1'b1;
            end
         end
         OP_FIFO: begin
            for (int c = 1; c < 3 && c < CHANNELS; c++) begin
               if (control_ff[c][15] && control_ff[c][13:12] == TIMING_SPECIAL
                   && dest_reg_ff[c] == fifo_addr)
                  pending_in[c] = 1'b1;
            end
         end
         OP_CAPTURE: begin
            for (int c = 3; c < CHANNELS; c++) begin
               if (control_ff[c][15] && control_ff[c][13:12] == TIMING_SPECIAL) begin
                  if (req.last_scanline) control_in[c][15] = 1'b0;
                  pending_in[c] = 1'b1;
               end
            end
         end
         OP_STEP: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (found && sel == 2'(c)) begin
                  ctl   = control_ff[c];
                  tm    = ctl[13:12];
                  audio = (tm == TIMING_SPECIAL) && (c != 3);
                  word  = ctl[10] || audio;
                  srule = ctl[8:7];
                  drule = audio ? RULE_FIXED : ctl[6:5];
                  smask = 32'(src_mask(c));
                  dmask = 32'(dst_mask(c));
                  src   = 32'(live_src_ff[c]) & smask;
                  dst   = 32'(live_dst_ff[c]) & dmask;
                  inc   = word ? 32'd4 : 32'd2;
                  blk   = 32'(count_reg_ff[c]);
                  if (c != 3) blk = blk & 32'h3FFF;
                  if (blk == 32'd0) blk = (c == 3) ? 32'h10000 : 32'h4000;
                  if (audio) blk = 32'd4;
                  ul = units_ff[c];
                  rl = reload_ff[c];
                  if (ul == 17'd0 || ul > 17'h10000) begin
                     ul = blk[16:0];
                     rl = 1'b0;
                  end
                  rsp.xfer_valid   = 1'b1;
                  rsp.xfer_channel = 2'(c);
                  rsp.src_addr = src[27:0] & (word ? ~28'd3 : ~28'd1);
                  rsp.dst_addr = dst[27:0] & (word ? ~28'd3 : ~28'd1);
                  rsp.word_size = word;
                  rsp.open_bus = (src <= 32'h01FFFFFF);
                  if (src >= 32'h08000000 && src <= 32'h0DFFFFFF) srule = RULE_INC;
                  if (srule == RULE_INC) begin
                     ns = src + inc;
                     if (ns == 32'h08000000 && dst >= 32'h08000000 &&
                         dst <= 32'h0DFFFFFF) ns = dst + 32'd2;
                     src = ns;
                  end else if (srule == RULE_DEC) begin
                     src = src - inc;
                  end
                  if (drule == RULE_INC) dst = dst + inc;
                  else if (drule == RULE_DEC) dst = dst - inc;
                  else if (drule == RULE_RELOAD) begin
                     dst = dst + inc;
                     rl = 1'b1;
                  end
                  live_src_in[c] = src[ADDR_BITS-1:0] & smask[ADDR_BITS-1:0];
                  live_dst_in[c] = dst[ADDR_BITS-1:0] & dmask[ADDR_BITS-1:0];
                  ul = ul - 17'd1;
                  reload_in[c] = rl;
                  if (ul == 17'd0) begin
                     rep = ctl[9] || audio;
                     rsp.block_done = 1'b1;
                     if (ctl[14]) rsp.irq_request = 4'(1 << c);
                     count_reg_in[c] = '0;
                     if (rep && tm != TIMING_NOW) begin
                        if (rl) live_dst_in[c] = dest_reg_ff[c][ADDR_BITS-1:0] &
                                                 dmask[ADDR_BITS-1:0];
                        count_reg_in[c] = blk[15:0];
                     end else begin
                        control_in[c][15] = 1'b0;
                     end
                     reload_in[c]  = 1'b0;
                     pending_in[c] = 1'b0;
                  end
                  units_in[c] = ul;
               end
            end
         end
         default: begin
         end
      endcase
      rsp.pending_mask = 4'(pending_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            source_reg_ff[c] <= '0;
            dest_reg_ff[c]   <= '0;
            count_reg_ff[c]  <= '0;
            control_ff[c]    <= '0;
            live_src_ff[c]   <= '0;
            live_dst_ff[c]   <= '0;
            units_ff[c]      <= '0;
         end
         pending_ff <= '0;
         reload_ff  <= '0;
      end else if (fire) begin
         for (int c = 0; c < CHANNELS; c++) begin
            source_reg_ff[c] <= source_reg_in[c];
            dest_reg_ff[c]   <= dest_reg_in[c];
            count_reg_ff[c]  <= count_reg_in[c];
            control_ff[c]    <= control_in[c];
            live_src_ff[c]   <= live_src_in[c];
            live_dst_ff[c]   <= live_dst_in[c];
            units_ff[c]      <= units_in[c];
         end
         pending_ff <= pending_in;
         reload_ff  <= reload_in;
      end
   end
endmodule

@@ sv/four_channel_dma_controller.sv @@
// Four-channel DMA address engine.
// Transactions arrive on the req channel: register writes and reads, the
// vblank, hblank, audio FIFO and video capture triggers, and steps. Each
// request transaction yields exactly one rsp transaction carrying the read
// byte, the address pair of the unit moved (if any) and the pending mask.
// A request is registered in an input stage; the channel state is updated
// and the response computed by a single pass of logic from that stage into
// the output register, from which the response is offered. While the
// receiver does not stall, one transaction is accepted every cycle.
// The per-channel register file updates as the input stage is consumed.
// While the receiver stalls, the output register holds its transaction and
// the input stage fills; once both are full req_ready falls.
// Synchronous reset clears every channel register, the pending flags and
// both pipeline stages; the block is ready once reset is released.
module four_channel_dma_controller (
   input  logic      clock,
   input  logic      reset,
   fcdma_req_if.sink   req,
   fcdma_rsp_if.source rsp
);
   import fcdma_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   logic    fire;

   assign fire = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || fire;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_data_ff;
   assign in_valid_in = req.valid || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp.ready);

   fcdma_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready) in_data_ff <= req.payload;
      if (fire) out_data_ff <= core_rsp;
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("response changed while stalled");
   a_full_not_ready: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp.ready |-> !req.ready)
      else $error("request accepted with both stages full");
   a_irq_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot0(rsp.payload.irq_request)
                  && (rsp.payload.xfer_valid || rsp.payload.irq_request == 4'd0))
      else $error("bad interrupt request");
endmodule
